/* src/rx_chunk_footer_deframer_assert.svh */
// Assertion macros for the receive chunk deframer.
// Each macro expects clk and rst to be visible where it is used.
`ifndef RX_CHUNK_FOOTER_DEFRAMER_ASSERT_SVH
`define RX_CHUNK_FOOTER_DEFRAMER_ASSERT_SVH

// Condition that must hold at every clock edge outside reset.
`define RCFD_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Consequence that must hold in the same cycle as the antecedent.
`define RCFD_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Consequence that must hold in the cycle after the antecedent.
`define RCFD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* src/rcfd_pkg.sv */
package rcfd_pkg;

  // Default chunk size limit in words.
  localparam int MAX_CHUNK_WORDS_DEF = 16;

  // Field widths.
  localparam int WORD_W = 32;
  localparam int PB_W   = 7;
  localparam int WCNT_W = 5;
  localparam int BYTE_W = 7;
  localparam int NB_W   = 3;
  localparam int ERR_W  = 3;
  localparam int STAT_W = 5;

  // Register reset value: 64-byte chunks.
  localparam logic [PB_W-1:0] PB_RESET = 7'd64;

  // Two buffer banks, one per queued job.
  localparam int BANKS  = 2;
  localparam int QPTR_W = 1;
  localparam int QCNT_W = 2;

  // Footer bit positions.
  localparam int FT_EXST   = 31;
  localparam int FT_SYNC   = 29;
  localparam int FT_RCA_HI = 28;
  localparam int FT_RCA_LO = 24;
  localparam int FT_DV     = 21;
  localparam int FT_SV     = 20;
  localparam int FT_SWO_HI = 19;
  localparam int FT_SWO_LO = 16;
  localparam int FT_FD     = 15;
  localparam int FT_EV     = 14;
  localparam int FT_EBO_HI = 13;
  localparam int FT_EBO_LO = 8;
  localparam int FT_TXC_HI = 5;
  localparam int FT_TXC_LO = 1;

  // Result error codes.
  typedef enum logic [ERR_W-1:0] {
    ERR_NONE    = 3'd0,
    ERR_PARITY  = 3'd1,
    ERR_NOSYNC  = 3'd2,
    ERR_NODATA  = 3'd3,
    ERR_DISCARD = 3'd4
  } err_t;

  // One contiguous run of bytes to send from a buffered chunk.
  typedef struct packed {
    logic [BYTE_W-1:0] off;
    logic [BYTE_W-1:0] len;
    logic              st;
    logic              en;
  } part_t;

  // Work handed from the front end to the back end for one footer.
  typedef struct packed {
    err_t              err;
    part_t             a;
    part_t             b;
    logic              bank;
    logic [STAT_W-1:0] rx_available;
    logic [STAT_W-1:0] tx_credits;
    logic              extended_status;
    logic              synced;
  } job_t;

  // Back end sequencer states.
  typedef enum logic [1:0] {
    BK_IDLE,
    BK_CHECK,
    BK_EMIT
  } bk_state_t;

endpackage

/* src/rcfd_in_if.sv */
interface rcfd_in_if;
  import rcfd_pkg::*;

  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] chunk_word;

  modport source (output valid, output chunk_word, input ready);
  modport sink (input valid, input chunk_word, output ready);
endinterface

/* src/rcfd_out_if.sv */
interface rcfd_out_if;
  import rcfd_pkg::*;

  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] data_word;
  logic [NB_W-1:0]   bytes_valid;
  logic              frame_start;
  logic              frame_end;
  logic [ERR_W-1:0]  error_code;
  logic              last;
  logic [STAT_W-1:0] rx_available;
  logic [STAT_W-1:0] tx_credits;
  logic              extended_status;
  logic              synced;

  modport source (
    output valid, output data_word, output bytes_valid, output frame_start,
    output frame_end, output error_code, output last, output rx_available,
    output tx_credits, output extended_status, output synced,
    input ready
  );
  modport sink (
    input valid, input data_word, input bytes_valid, input frame_start,
    input frame_end, input error_code, input last, input rx_available,
    input tx_credits, input extended_status, input synced,
    output ready
  );
endinterface

/* src/rcfd_buf.sv */
module rcfd_buf #(
  parameter int MAX_CHUNK_WORDS = rcfd_pkg::MAX_CHUNK_WORDS_DEF
) (
  input  logic                                       clk,
  input  logic                                       wr_en,
  input  logic [$clog2(MAX_CHUNK_WORDS):0]           wr_addr,
  input  logic [rcfd_pkg::WORD_W-1:0]                wr_data,
  input  logic                                       rd_en,
  input  logic [$clog2(MAX_CHUNK_WORDS):0]           rd_addr,
  output logic [rcfd_pkg::WORD_W-1:0]                rd_data
);
  import rcfd_pkg::*;

  localparam int IDX_W = $clog2(MAX_CHUNK_WORDS);
  localparam int DEPTH = BANKS << IDX_W;

  logic [WORD_W-1:0] mem [DEPTH];

  // Write port, driven by the front end.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port, driven by the back end.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end
endmodule

/* src/rcfd_queue.sv */
module rcfd_queue (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push,
  input  rcfd_pkg::job_t              push_job,
  input  logic                        pop,
  output rcfd_pkg::job_t              head,
  output logic [rcfd_pkg::QCNT_W-1:0] count
);
  import rcfd_pkg::*;

  job_t              entries [BANKS];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + QCNT_W'(push) - QCNT_W'(pop);
    end
  end

  // Job storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  assign head = entries[rd_ptr];
endmodule

/* src/rcfd_front.sv */
module rcfd_front #(
  parameter int MAX_CHUNK_WORDS = rcfd_pkg::MAX_CHUNK_WORDS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [rcfd_pkg::PB_W-1:0]         cfg_data,
  rcfd_in_if.sink                           in_ch,
  input  logic [rcfd_pkg::QCNT_W-1:0]       q_count,
  output logic                              wr_en,
  output logic [$clog2(MAX_CHUNK_WORDS):0]  wr_addr,
  output logic [rcfd_pkg::WORD_W-1:0]       wr_data,
  output logic                              push,
  output rcfd_pkg::job_t                    push_job
);
  import rcfd_pkg::*;

  localparam int IDX_W = $clog2(MAX_CHUNK_WORDS);

  logic [PB_W-1:0]   payload_bytes;
  logic [WCNT_W-1:0] word_counter;
  logic              bank;
  logic [STAT_W-1:0] rx_chunks_available;
  logic [STAT_W-1:0] tx_credit_count;
  logic              ext_status_flag;
  logic              sync_flag;

  logic [WCNT_W-1:0] words_raw;
  logic [WCNT_W-1:0] words;
  logic [BYTE_W-1:0] cps;
  logic              accept;
  logic              is_footer;
  logic [WORD_W-1:0] w;
  logic              par_ok;
  logic              f_sv;
  logic              f_ev;
  logic [BYTE_W-1:0] sbo;
  logic [BYTE_W-1:0] ebo;
  logic [BYTE_W-1:0] sbo_c;
  logic [BYTE_W-1:0] ebo_c;

  // Chunk size in words, held within the supported range.
  always_comb begin
    words_raw = payload_bytes[PB_W-1:2];
    if (words_raw < WCNT_W'(2)) begin
      words = WCNT_W'(2);
    end else if (words_raw > WCNT_W'(MAX_CHUNK_WORDS)) begin
      words = WCNT_W'(MAX_CHUNK_WORDS);
    end else begin
      words = words_raw;
    end
  end

  assign cps = {words, 2'b00};

  // Handshake: stall while both buffer banks hold unfinished chunks.
  assign in_ch.ready = (q_count < QCNT_W'(BANKS));
  assign accept      = in_ch.valid & in_ch.ready;
  assign is_footer   = !(word_counter < words);
  assign w           = in_ch.chunk_word;

  // Payload words go straight into the current bank.
  assign wr_en   = accept & !is_footer;
  assign wr_addr = {bank, word_counter[IDX_W-1:0]};
  assign wr_data = w;
  assign push    = accept & is_footer;

  // Footer decode: offsets, clipping and the error ladder.
  assign par_ok = ^w;
  assign f_sv   = w[FT_SV];
  assign f_ev   = w[FT_EV];
  assign sbo    = {1'b0, w[FT_SWO_HI:FT_SWO_LO], 2'b00};
  assign ebo    = {1'b0, w[FT_EBO_HI:FT_EBO_LO]} + BYTE_W'(1);
  assign sbo_c  = (sbo > cps) ? cps : sbo;
  assign ebo_c  = (ebo > cps) ? cps : ebo;

  always_comb begin
    push_job      = '0;
    push_job.bank = bank;

    // Status as it stands after this footer.
    if (par_ok) begin
      push_job.rx_available    = w[FT_RCA_HI:FT_RCA_LO];
      push_job.tx_credits      = w[FT_TXC_HI:FT_TXC_LO];
      push_job.extended_status = w[FT_EXST];
      push_job.synced          = w[FT_SYNC];
    end else begin
      push_job.rx_available    = rx_chunks_available;
      push_job.tx_credits      = tx_credit_count;
      push_job.extended_status = ext_status_flag;
      push_job.synced          = sync_flag;
    end

    if (!par_ok) begin
      push_job.err = ERR_PARITY;
    end else if (!w[FT_SYNC]) begin
      push_job.err = ERR_NOSYNC;
    end else if (!w[FT_DV]) begin
      push_job.err = ERR_NODATA;
    end else if (f_ev && w[FT_FD]) begin
      push_job.err = ERR_DISCARD;
    end else begin
      push_job.err = ERR_NONE;
    end

    // Split the chunk into at most two runs, the ending one first.
    if (f_sv && f_ev && !(ebo > sbo)) begin
      push_job.a = '{off: '0, len: ebo_c, st: 1'b0, en: 1'b1};
      push_job.b = '{off: sbo_c, len: cps - sbo_c, st: 1'b1, en: 1'b0};
    end else if (f_sv && f_ev) begin
      push_job.a = '{off: sbo_c, len: (ebo_c > sbo_c) ? ebo_c - sbo_c : '0,
                     st: 1'b1, en: 1'b1};
    end else if (f_sv) begin
      push_job.a = '{off: sbo_c, len: cps - sbo_c, st: 1'b1, en: 1'b0};
    end else if (f_ev) begin
      push_job.a = '{off: '0, len: ebo_c, st: 1'b0, en: 1'b1};
    end else begin
      push_job.a = '{off: '0, len: cps, st: 1'b0, en: 1'b0};
    end
  end

  // Configuration, word count, bank select and tracked status.
  always_ff @(posedge clk) begin
    if (rst) begin
      payload_bytes       <= PB_RESET;
      word_counter        <= '0;
      bank                <= 1'b0;
      rx_chunks_available <= '0;
      tx_credit_count     <= '0;
      ext_status_flag     <= 1'b0;
      sync_flag           <= 1'b0;
    end else begin
      if (cfg_write) begin
        payload_bytes <= cfg_data;
      end
      if (accept) begin
        word_counter <= is_footer ? '0 : word_counter + WCNT_W'(1);
      end
      if (push) begin
        bank <= ~bank;
        if (par_ok) begin
          rx_chunks_available <= w[FT_RCA_HI:FT_RCA_LO];
          tx_credit_count     <= w[FT_TXC_HI:FT_TXC_LO];
          ext_status_flag     <= w[FT_EXST];
          sync_flag           <= w[FT_SYNC];
        end
      end
    end
  end
endmodule

/* src/rcfd_back.sv */
module rcfd_back #(
  parameter int MAX_CHUNK_WORDS = rcfd_pkg::MAX_CHUNK_WORDS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic [rcfd_pkg::QCNT_W-1:0]       q_count,
  input  rcfd_pkg::job_t                    head,
  output logic                              pop,
  output logic                              rd_en,
  output logic [$clog2(MAX_CHUNK_WORDS):0]  rd_addr,
  input  logic [rcfd_pkg::WORD_W-1:0]       rd_data,
  rcfd_out_if.source                        out_ch
);
  import rcfd_pkg::*;

  localparam int IDX_W = $clog2(MAX_CHUNK_WORDS);

  bk_state_t         state;
  bk_state_t         state_next;
  logic              phase;
  logic              first;
  logic [IDX_W-1:0]  idx;
  logic [BYTE_W-1:0] left;
  err_t              o_err;
  logic [NB_W-1:0]   o_nb;
  logic              o_st;
  logic              o_en;
  logic              o_last;

  logic              q_nonempty;
  part_t             part;
  logic [NB_W-1:0]   nb;
  logic [BYTE_W-1:0] left_n;
  logic [WORD_W-1:0] mask;

  assign q_nonempty = (q_count != '0);
  assign part       = phase ? head.b : head.a;
  assign nb         = (left > BYTE_W'(4)) ? NB_W'(4) : left[NB_W-1:0];
  assign left_n     = left - BYTE_W'(nb);
  assign rd_addr    = {head.bank, idx};

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      BK_IDLE: begin
        if (q_nonempty) begin
          state_next = (head.err != ERR_NONE) ? BK_EMIT : BK_CHECK;
        end
      end
      BK_CHECK: begin
        if (left == '0) begin
          state_next = phase ? BK_IDLE : BK_CHECK;
        end else begin
          state_next = BK_EMIT;
        end
      end
      BK_EMIT: begin
        if (out_ch.ready) begin
          state_next = o_last ? BK_IDLE : BK_CHECK;
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  // Control outputs.
  always_comb begin
    pop          = 1'b0;
    rd_en        = 1'b0;
    out_ch.valid = 1'b0;
    unique case (state)
      BK_IDLE: ;
      BK_CHECK: begin
        rd_en = (left != '0);
        pop   = (left == '0) && phase;
      end
      BK_EMIT: begin
        out_ch.valid = 1'b1;
        pop          = out_ch.ready && o_last;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Walk the runs of the head job one word at a time.
  always_ff @(posedge clk) begin
    case (state)
      BK_IDLE: begin
        if (q_nonempty) begin
          phase <= 1'b0;
          if (head.err != ERR_NONE) begin
            o_err  <= head.err;
            o_nb   <= '0;
            o_st   <= 1'b0;
            o_en   <= 1'b0;
            o_last <= 1'b1;
          end else begin
            idx   <= head.a.off[IDX_W+1:2];
            left  <= head.a.len;
            first <= 1'b1;
          end
        end
      end
      BK_CHECK: begin
        if (left == '0) begin
          if (!phase) begin
            phase <= 1'b1;
            idx   <= head.b.off[IDX_W+1:2];
            left  <= head.b.len;
            first <= 1'b1;
          end
        end else begin
          o_err  <= ERR_NONE;
          o_nb   <= nb;
          o_st   <= first & part.st;
          o_en   <= (left_n == '0) & part.en;
          o_last <= (left_n == '0) & (phase | (head.b.len == '0));
          left   <= left_n;
          idx    <= idx + IDX_W'(1);
          first  <= 1'b0;
        end
      end
      default: ;
    endcase
  end

  // Keep only the leading valid bytes.
  always_comb begin
    case (o_nb)
      3'd1:    mask = 32'hFF00_0000;
      3'd2:    mask = 32'hFFFF_0000;
      3'd3:    mask = 32'hFFFF_FF00;
      default: mask = 32'hFFFF_FFFF;
    endcase
  end

  // Result payload.
  assign out_ch.data_word       = (o_err != ERR_NONE) ? '0 : (rd_data & mask);
  assign out_ch.bytes_valid     = o_nb;
  assign out_ch.frame_start     = o_st;
  assign out_ch.frame_end       = o_en;
  assign out_ch.error_code      = o_err;
  assign out_ch.last            = o_last;
  assign out_ch.rx_available    = head.rx_available;
  assign out_ch.tx_credits      = head.tx_credits;
  assign out_ch.extended_status = head.extended_status;
  assign out_ch.synced          = head.synced;
endmodule

/* src/rx_chunk_footer_deframer.sv */
// Receive data chunk deframer. Payload words are written into one of two
// buffer banks as they arrive; the footer word closes the chunk, is checked
// for odd parity, SYNC, DV and frame discard, and queues a job for the
// output side, which then sends the chunk's frame words (start offset and
// end byte applied, marks set) or one error result. A job is started from
// the idle state; each result word is read from the buffer and then
// presented, and is held until it is taken. A chunk that ends one frame
// and starts the next takes an extra check step to move to its second run.
// Input is stalled only while both banks hold chunks whose results are not
// yet all taken. The buffer needs no clearing after reset; payload_bytes may
// be changed only while the block is idle.
`include "rx_chunk_footer_deframer_assert.svh"

module rx_chunk_footer_deframer #(
  parameter int MAX_CHUNK_WORDS = rcfd_pkg::MAX_CHUNK_WORDS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_write,
  input  logic [rcfd_pkg::PB_W-1:0] cfg_data,
  rcfd_in_if.sink                   in_ch,
  rcfd_out_if.source                out_ch
);
  import rcfd_pkg::*;

  localparam int ADDR_W = $clog2(MAX_CHUNK_WORDS) + 1;

  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [WORD_W-1:0] wr_data;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic [WORD_W-1:0] rd_data;
  logic              push;
  job_t              push_job;
  logic              pop;
  job_t              head;
  logic [QCNT_W-1:0] q_count;

  // Front end: takes words, fills the buffer, decodes footers.
  rcfd_front #(
    .MAX_CHUNK_WORDS(MAX_CHUNK_WORDS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg_write(cfg_write),
    .cfg_data (cfg_data),
    .in_ch    (in_ch),
    .q_count  (q_count),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data),
    .push     (push),
    .push_job (push_job)
  );

  // Two-bank payload buffer.
  rcfd_buf #(
    .MAX_CHUNK_WORDS(MAX_CHUNK_WORDS)
  ) u_buf (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  // Job queue between the two sides.
  rcfd_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_job(push_job),
    .pop     (pop),
    .head    (head),
    .count   (q_count)
  );

  // Back end: sends the results of each job.
  rcfd_back #(
    .MAX_CHUNK_WORDS(MAX_CHUNK_WORDS)
  ) u_back (
    .clk    (clk),
    .rst    (rst),
    .q_count(q_count),
    .head   (head),
    .pop    (pop),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data),
    .out_ch (out_ch)
  );

  // Checks.
  `RCFD_ASSERT_ALWAYS(a_queue_bound, q_count <= QCNT_W'(BANKS), "job queue overflow")
  `RCFD_ASSERT_IMPL(a_err_alone, out_ch.valid && (out_ch.error_code != ERR_NONE), out_ch.last && (out_ch.bytes_valid == '0) && (out_ch.data_word == '0), "error result malformed")
  `RCFD_ASSERT_IMPL(a_ok_bytes, out_ch.valid && (out_ch.error_code == ERR_NONE), (out_ch.bytes_valid != '0) && (out_ch.bytes_valid <= 3'd4), "data result byte count out of range")
  `RCFD_ASSERT_NEXT(a_stall_keeps_job, out_ch.valid && !out_ch.ready, q_count >= $past(q_count), "job released while result stalled")
endmodule
